[sv/pncr_pkg.sv]
`timescale 1ns / 1ps
// shared constants, types and state codes of the palette nearest color remapper
package pncr_pkg;

  // field widths
  localparam int IDX_W       = 8;
  localparam int COLOR_W     = 24;
  localparam int ARGB_W      = 32;
  localparam int CH_W        = 8;
  localparam int SQ_W        = 2 * CH_W;
  localparam int DIST_W      = SQ_W + 2;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 8;

  // palette size and the highest index the search may return
  localparam int PALETTE_ENTRIES   = 256;
  localparam int LAST_OPAQUE       = 254;
  localparam int SEARCH_LIMIT      = (PALETTE_ENTRIES - 1 < LAST_OPAQUE) ?
                                     (PALETTE_ENTRIES - 1) : LAST_OPAQUE;
  localparam logic [IDX_W-1:0] TRANSPARENT_INDEX = 8'd255;

  // row of cells, each owning one bank of the palette
  localparam int CELL_COUNT = 8;
  localparam int CELL_W     = $clog2(CELL_COUNT);
  localparam int BANK_SPAN  = (PALETTE_ENTRIES + CELL_COUNT - 1) / CELL_COUNT;
  localparam int BANK_AW    = (BANK_SPAN > 1) ? $clog2(BANK_SPAN) : 1;
  localparam int BANK_DEPTH = 1 << BANK_AW;
  localparam int GIDX_W     = CELL_W + BANK_AW;

  // end value of the counter for the candidate chain phase after the sweep, and its width
  localparam int CHAIN_CYCLES = CELL_COUNT + 2;
  localparam int CHAIN_W      = $clog2(CHAIN_CYCLES + 1);

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_RESERVE = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CUTOFF  = 4'd1;

  // operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_MAP   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_CHAIN,
    ST_DONE
  } state_t;

  // broadcast scan control for all cells
  typedef struct packed {
    logic               valid;
    logic               first;
    logic [BANK_AW-1:0] addr;
    logic [COLOR_W-1:0] rgb;
  } scan_t;

  // palette write for one bank
  typedef struct packed {
    logic               en;
    logic [BANK_AW-1:0] addr;
    logic [COLOR_W-1:0] data;
  } pal_wr_t;

  // best candidate passed along the row
  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] sqdist;
    logic [GIDX_W-1:0] index;
  } cand_t;

endpackage

[sv/pncr_ram.sv]
`timescale 1ns / 1ps
// generic single write, single read memory with registered read data
module pncr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[sv/pncr_cell.sv]
`timescale 1ns / 1ps
// one palette cell: a bank of entries, a distance unit and a link of the candidate chain
module pncr_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [pncr_pkg::CELL_W-1:0]  cell_id,
  input  pncr_pkg::pal_wr_t            wr,
  input  pncr_pkg::scan_t              scan,
  input  pncr_pkg::cand_t              chain_in,
  output pncr_pkg::cand_t              chain_out
);

  logic [pncr_pkg::COLOR_W-1:0] rd_data;

  // stage one: read data is in flight
  logic                         v1;
  logic                         f1;
  logic [pncr_pkg::BANK_AW-1:0] a1;

  // stage two: channel squares
  logic                         v2;
  logic                         f2;
  logic [pncr_pkg::BANK_AW-1:0] a2;
  logic [pncr_pkg::SQ_W-1:0]    sq_r;
  logic [pncr_pkg::SQ_W-1:0]    sq_g;
  logic [pncr_pkg::SQ_W-1:0]    sq_b;
  logic [pncr_pkg::SQ_W-1:0]    sq_r_next;
  logic [pncr_pkg::SQ_W-1:0]    sq_g_next;
  logic [pncr_pkg::SQ_W-1:0]    sq_b_next;

  // stage three: distance and local best
  logic [pncr_pkg::DIST_W-1:0]  cur_sqdist;
  logic [pncr_pkg::GIDX_W-1:0]  gidx;
  logic                         included;
  pncr_pkg::cand_t              best;
  pncr_pkg::cand_t              best_next;
  pncr_pkg::cand_t              cur;
  pncr_pkg::cand_t              merged;

  function automatic logic [pncr_pkg::SQ_W-1:0] sq_diff(
    input logic [pncr_pkg::CH_W-1:0] a,
    input logic [pncr_pkg::CH_W-1:0] b
  );
    logic [pncr_pkg::CH_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return pncr_pkg::SQ_W'(d) * pncr_pkg::SQ_W'(d);
  endfunction

  pncr_ram #(
    .WIDTH (pncr_pkg::COLOR_W),
    .DEPTH (pncr_pkg::BANK_DEPTH)
  ) u_bank (
    .clk     (clk),
    .wr_en   (wr.en),
    .wr_addr (wr.addr),
    .wr_data (wr.data),
    .rd_addr (scan.addr),
    .rd_data (rd_data)
  );

  // squares of the channel differences
  always_comb begin
    sq_r_next = sq_diff(scan.rgb[23:16], rd_data[23:16]);
    sq_g_next = sq_diff(scan.rgb[15:8],  rd_data[15:8]);
    sq_b_next = sq_diff(scan.rgb[7:0],   rd_data[7:0]);
  end

  // scan pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= scan.valid;
      v2 <= v1;
    end
  end

  // scan pipeline payload
  always_ff @(posedge clk) begin
    f1   <= scan.first;
    a1   <= scan.addr;
    f2   <= f1;
    a2   <= a1;
    sq_r <= sq_r_next;
    sq_g <= sq_g_next;
    sq_b <= sq_b_next;
  end

  // candidate for the entry now in stage three
  always_comb begin
    cur_sqdist = pncr_pkg::DIST_W'(sq_r) + pncr_pkg::DIST_W'(sq_g) +
                 pncr_pkg::DIST_W'(sq_b);
    gidx       = {cell_id, a2};
    included   = (gidx <= pncr_pkg::GIDX_W'(pncr_pkg::SEARCH_LIMIT));
    cur.valid  = included;
    cur.sqdist = cur_sqdist;
    cur.index  = gidx;
  end

  // local best: strict less keeps the lowest index on ties
  always_comb begin
    best_next = best;
    if (v2) begin
      if (f2) begin
        best_next = cur;
      end else if (included && (!best.valid || (cur_sqdist < best.sqdist))) begin
        best_next = cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best.valid <= 1'b0;
    end else begin
      best.valid <= best_next.valid;
    end
    best.sqdist <= best_next.sqdist;
    best.index  <= best_next.index;
  end

  // chain link: the lower indices from the left win ties
  always_comb begin
    merged = chain_in;
    if (best.valid && (!chain_in.valid || (best.sqdist < chain_in.sqdist))) begin
      merged = best;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_out.valid <= 1'b0;
    end else begin
      chain_out.valid <= merged.valid;
    end
    chain_out.sqdist <= merged.sqdist;
    chain_out.index  <= merged.index;
  end

endmodule

[sv/palette_nearest_color_remap_top.sv]
`timescale 1ns / 1ps
// top level of the palette nearest color remapper: sequencer, registers and cell row
//
//   channel   direction  handshake              payload
//   in        input      in_valid / in_ready    operation, entry_index, entry_color,
//                                               pixel_argb, initial_index
//   out       output     out_valid / out_ready  out_index
//   cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// a palette write is done at acceptance; a map with no search goes straight to done
// a map that searches passes through the sweep and chain states before done:
// every cell sweeps its 32-entry bank through one memory port, then the best
// candidate ripples through the row of 8 cells
// rst is synchronous; it resets the sequencer, the output valid and the configuration registers
// a stalled output keeps its result; the next finished result waits in the done
// state, and while it waits no input transaction is taken
module palette_nearest_color_remap_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             operation,
  input  logic [pncr_pkg::IDX_W-1:0]       entry_index,
  input  logic [pncr_pkg::COLOR_W-1:0]     entry_color,
  input  logic [pncr_pkg::ARGB_W-1:0]      pixel_argb,
  input  logic [pncr_pkg::IDX_W-1:0]       initial_index,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [pncr_pkg::IDX_W-1:0]       out_index,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pncr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pncr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  pncr_pkg::state_t                  state;
  pncr_pkg::state_t                  state_next;
  logic [pncr_pkg::BANK_AW-1:0]      sweep_cnt;
  logic [pncr_pkg::CHAIN_W-1:0]      chain_cnt;
  logic [pncr_pkg::COLOR_W-1:0]      pixel_rgb;
  logic [pncr_pkg::IDX_W-1:0]        res_index;
  logic                              reserve_transparent;
  logic [pncr_pkg::CH_W-1:0]         cutoff_level;

  logic                              in_fire;
  logic                              map_fire;
  logic                              need_search;
  logic [pncr_pkg::IDX_W-1:0]        pass_index;
  logic                              sweep_last;
  logic                              chain_last;
  logic                              out_free;
  logic                              out_load;
  logic                              in_range;

  pncr_pkg::scan_t                   scan;
  pncr_pkg::pal_wr_t                 wr     [pncr_pkg::CELL_COUNT];
  pncr_pkg::cand_t                   chain  [pncr_pkg::CELL_COUNT+1];
  pncr_pkg::cand_t                   tail;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      reserve_transparent <= 1'b1;
      cutoff_level        <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == pncr_pkg::CFG_RESERVE) begin
        reserve_transparent <= cfg_data[0];
      end else if (cfg_index == pncr_pkg::CFG_CUTOFF) begin
        cutoff_level <= cfg_data;
      end
    end
  end

  // map decision at acceptance
  always_comb begin
    in_fire     = in_valid && in_ready;
    map_fire    = in_fire && (operation == pncr_pkg::OP_MAP);
    need_search = 1'b0;
    pass_index  = initial_index;
    if (reserve_transparent) begin
      if (pixel_argb[31:24] <= cutoff_level) begin
        pass_index = pncr_pkg::TRANSPARENT_INDEX;
      end else if (initial_index == pncr_pkg::TRANSPARENT_INDEX) begin
        need_search = 1'b1;
      end
    end
  end

  assign sweep_last = (sweep_cnt == pncr_pkg::BANK_AW'(pncr_pkg::BANK_DEPTH - 1));
  assign chain_last = (chain_cnt == pncr_pkg::CHAIN_W'(pncr_pkg::CHAIN_CYCLES));
  assign out_free   = !out_valid || out_ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      pncr_pkg::ST_IDLE: begin
        if (map_fire) begin
          state_next = need_search ? pncr_pkg::ST_SWEEP : pncr_pkg::ST_DONE;
        end
      end
      pncr_pkg::ST_SWEEP: begin
        if (sweep_last) begin
          state_next = pncr_pkg::ST_CHAIN;
        end
      end
      pncr_pkg::ST_CHAIN: begin
        if (chain_last) begin
          state_next = pncr_pkg::ST_DONE;
        end
      end
      pncr_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = pncr_pkg::ST_IDLE;
        end
      end
      default: state_next = pncr_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready   = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      pncr_pkg::ST_IDLE:  in_ready   = 1'b1;
      pncr_pkg::ST_SWEEP: ;
      pncr_pkg::ST_CHAIN: ;
      pncr_pkg::ST_DONE:  out_load   = out_free;
      default: ;
    endcase
  end

  // scan broadcast
  always_comb begin
    scan.valid = (state == pncr_pkg::ST_SWEEP);
    scan.first = (sweep_cnt == '0);
    scan.addr  = sweep_cnt;
    scan.rgb   = pixel_rgb;
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pncr_pkg::ST_IDLE;
      sweep_cnt <= '0;
      chain_cnt <= '0;
    end else begin
      state     <= state_next;
      sweep_cnt <= (state == pncr_pkg::ST_SWEEP) ? sweep_cnt + 1'b1 : '0;
      chain_cnt <= (state == pncr_pkg::ST_CHAIN) ? chain_cnt + 1'b1 : '0;
    end
  end

  // pixel and result holding
  always_ff @(posedge clk) begin
    if (map_fire) begin
      pixel_rgb <= pixel_argb[pncr_pkg::COLOR_W-1:0];
      res_index <= pass_index;
    end else if ((state == pncr_pkg::ST_CHAIN) && chain_last) begin
      res_index <= pncr_pkg::IDX_W'(tail.index);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_index <= res_index;
    end
  end

  // palette write routing
  assign in_range = (int'(entry_index) < pncr_pkg::PALETTE_ENTRIES);

  assign chain[0] = '0;
  assign tail     = chain[pncr_pkg::CELL_COUNT];

  for (genvar j = 0; j < pncr_pkg::CELL_COUNT; j++) begin : g_cell
    always_comb begin
      wr[j].en   = in_fire && (operation == pncr_pkg::OP_WRITE) && in_range &&
                   ((entry_index >> pncr_pkg::BANK_AW) == pncr_pkg::IDX_W'(j));
      wr[j].addr = entry_index[pncr_pkg::BANK_AW-1:0];
      wr[j].data = entry_color;
    end

    pncr_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cell_id   (pncr_pkg::CELL_W'(j)),
      .wr        (wr[j]),
      .scan      (scan),
      .chain_in  (chain[j]),
      .chain_out (chain[j+1])
    );
  end

  // the row always settles on an opaque index when the search ends
  a_search_result: assert property (@(posedge clk) disable iff (rst)
    ((state == pncr_pkg::ST_CHAIN) && chain_last) |->
      (tail.valid && (tail.index <= pncr_pkg::GIDX_W'(pncr_pkg::SEARCH_LIMIT))))
    else $error("search ended without a valid opaque candidate");

  // a result appears only from the done state
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == pncr_pkg::ST_DONE))
    else $error("result raised outside the done state");

  // no transaction is taken while the banks are being swept
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    scan.valid |-> !in_fire)
    else $error("input accepted during a sweep");

endmodule
